// ----- rtl/core/mm_pkg.sv -----
// shared constants, types and helpers for the matrix multiply block
`default_nettype none

package mm_pkg;

    // largest matrix dimension held in the stores
    localparam int MAX_DIM     = 8;
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int DIM_W       = $clog2(MAX_DIM + 1);
    localparam int LC_W        = $clog2(2 * STORE_DEPTH + 1);

    // fixed field widths
    localparam int CFG_W  = 4;
    localparam int IDX_W  = 2;
    localparam int ELEM_W = 16;
    localparam int PROD_W = 2 * ELEM_W;
    localparam int ACC_W  = 40;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_ROWS_A    = 2'd0;
    localparam logic [IDX_W-1:0] REG_INNER_DIM = 2'd1;
    localparam logic [IDX_W-1:0] REG_COLS_B    = 2'd2;

    // clamp a raw dimension register into 1..MAX_DIM
    function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] raw);
        logic [DIM_W-1:0] res;
        if (raw == '0)
            res = DIM_W'(1);
        else if (int'(raw) > MAX_DIM)
            res = DIM_W'(MAX_DIM);
        else
            res = DIM_W'(raw);
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/matrix_multiply.sv -----
// matrix multiply top level: load stores, shared multiply-accumulate, result output
//
// usage
//   configuration: write rows_a (index 0), inner_dim (1) and cols_b (2) on the
//   cfg_valid / cfg_ready / cfg_index / cfg_data channel while the block is idle;
//   cfg_ready is always high. A write to a known index restarts loading with A.
//   input: each word is taken when start is high and busy is low. Send the
//   M*K words of A, then the K*N words of B, each row-major, one per cycle.
//   output: after the last word of B, busy rises and M*N product words come out
//   row-major on product, each marked by done for one cycle; last flags the final.
//   computation: one multiply-accumulate unit does one product per cycle, and busy
//   falls with the final result.
//   The receiver cannot stall: every done word must be taken in its cycle.
//   reset: dimensions return to 1, the load counter clears, busy and done go low.
//   Store contents are not cleared; every entry read is written during loading.
`default_nettype none

module matrix_multiply
    import mm_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    // configuration channel
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [IDX_W-1:0]         cfg_index,
    input  wire logic [CFG_W-1:0]         cfg_data,
    // input words
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic signed [ELEM_W-1:0] element,
    // result words
    output logic                          done,
    output logic signed [ACC_W-1:0]       product,
    output logic                          last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN
    } state_t;

    // configuration registers
    logic [CFG_W-1:0] rows_a_reg;
    logic [CFG_W-1:0] inner_dim_reg;
    logic [CFG_W-1:0] cols_b_reg;

    // control state
    state_t            state_reg;
    logic [LC_W-1:0]   load_count_reg;
    logic [DIM_W-1:0]  i_reg;
    logic [DIM_W-1:0]  j_reg;
    logic [DIM_W-1:0]  t_reg;
    logic [ADDR_W-1:0] a_row_reg;
    logic [ADDR_W-1:0] a_addr_reg;
    logic [ADDR_W-1:0] b_addr_reg;
    logic              s1_valid_reg;
    logic              s1_first_reg;
    logic              s1_end_reg;
    logic              s1_final_reg;
    logic              s2_valid_reg;
    logic              s2_first_reg;
    logic              s2_end_reg;
    logic              s2_final_reg;
    logic              done_reg;
    logic              last_reg;

    // datapath
    logic signed [ELEM_W-1:0] a_mem [STORE_DEPTH];
    logic signed [ELEM_W-1:0] b_mem [STORE_DEPTH];
    logic signed [ELEM_W-1:0] a_q_reg;
    logic signed [ELEM_W-1:0] b_q_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  product_reg;
    logic signed [ACC_W-1:0]  acc_next;

    // effective dimensions and load bookkeeping
    logic [DIM_W-1:0]  dim_m;
    logic [DIM_W-1:0]  dim_k;
    logic [DIM_W-1:0]  dim_n;
    logic [LC_W-1:0]   size_a;
    logic [LC_W-1:0]   size_total;
    logic [LC_W-1:0]   lc_eff;
    logic [LC_W-1:0]   lc_b;
    logic [LC_W-1:0]   lc_inc;
    logic              accept;
    logic              cfg_write;
    logic              cfg_known;
    logic              wr_a;
    logic              t_end;
    logic              j_end;
    logic              i_end;

    assign dim_m      = eff_dim(rows_a_reg);
    assign dim_k      = eff_dim(inner_dim_reg);
    assign dim_n      = eff_dim(cols_b_reg);
    assign size_a     = LC_W'(LC_W'(dim_m) * LC_W'(dim_k));
    assign size_total = LC_W'(size_a + LC_W'(LC_W'(dim_k) * LC_W'(dim_n)));
    assign lc_eff     = (load_count_reg >= size_total) ? '0 : load_count_reg;
    assign lc_b       = LC_W'(lc_eff - size_a);
    assign lc_inc     = LC_W'(lc_eff + LC_W'(1));
    assign wr_a       = (lc_eff < size_a);

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign cfg_known = (cfg_index == REG_ROWS_A) || (cfg_index == REG_INNER_DIM)
                    || (cfg_index == REG_COLS_B);

    // loop end detection for the inner, column and row counters
    assign t_end = (t_reg == DIM_W'(dim_k - DIM_W'(1)));
    assign j_end = (j_reg == DIM_W'(dim_n - DIM_W'(1)));
    assign i_end = (i_reg == DIM_W'(dim_m - DIM_W'(1)));

    // accumulate: a new sum starts on the first product of a dot product
    assign acc_next = (s2_first_reg ? '0 : acc_reg) + ACC_W'(prod_reg);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg    <= CFG_W'(1);
            inner_dim_reg <= CFG_W'(1);
            cols_b_reg    <= CFG_W'(1);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_ROWS_A:    rows_a_reg    <= cfg_data;
                REG_INNER_DIM: inner_dim_reg <= cfg_data;
                REG_COLS_B:    cols_b_reg    <= cfg_data;
                default:       ;
            endcase
        end
    end

    // sequencer: load counting, loop counters, pipeline flags and output strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            load_count_reg <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            t_reg          <= '0;
            a_row_reg      <= '0;
            a_addr_reg     <= '0;
            b_addr_reg     <= '0;
            s1_valid_reg   <= 1'b0;
            s1_first_reg   <= 1'b0;
            s1_end_reg     <= 1'b0;
            s1_final_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s2_first_reg   <= 1'b0;
            s2_end_reg     <= 1'b0;
            s2_final_reg   <= 1'b0;
            done_reg       <= 1'b0;
            last_reg       <= 1'b0;
        end
        else
        begin
            // pipeline flags move every cycle; a new issue happens only while running
            s1_valid_reg <= (state_reg == S_RUN);
            s2_valid_reg <= s1_valid_reg;
            s2_first_reg <= s1_first_reg;
            s2_end_reg   <= s1_end_reg;
            s2_final_reg <= s1_final_reg;
            done_reg     <= s2_valid_reg && s2_end_reg;
            last_reg     <= s2_valid_reg && s2_final_reg;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (cfg_write && cfg_known)
                    begin
                        load_count_reg <= '0;
                    end
                    else if (accept)
                    begin
                        if (lc_inc == size_total)
                        begin
                            load_count_reg <= '0;
                            state_reg      <= S_RUN;
                            i_reg          <= '0;
                            j_reg          <= '0;
                            t_reg          <= '0;
                            a_row_reg      <= '0;
                            a_addr_reg     <= '0;
                            b_addr_reg     <= '0;
                        end
                        else
                        begin
                            load_count_reg <= lc_inc;
                        end
                    end
                end

                S_RUN:
                begin
                    // issue one multiply-accumulate per cycle
                    s1_first_reg <= (t_reg == '0);
                    s1_end_reg   <= t_end;
                    s1_final_reg <= t_end && j_end && i_end;
                    if (!t_end)
                    begin
                        t_reg      <= DIM_W'(t_reg + DIM_W'(1));
                        a_addr_reg <= ADDR_W'(a_addr_reg + ADDR_W'(1));
                        b_addr_reg <= ADDR_W'(b_addr_reg + ADDR_W'(dim_n));
                    end
                    else if (!j_end)
                    begin
                        t_reg      <= '0;
                        j_reg      <= DIM_W'(j_reg + DIM_W'(1));
                        a_addr_reg <= a_row_reg;
                        b_addr_reg <= ADDR_W'(ADDR_W'(j_reg) + ADDR_W'(1));
                    end
                    else if (!i_end)
                    begin
                        t_reg      <= '0;
                        j_reg      <= '0;
                        i_reg      <= DIM_W'(i_reg + DIM_W'(1));
                        a_row_reg  <= ADDR_W'(a_row_reg + ADDR_W'(dim_k));
                        a_addr_reg <= ADDR_W'(a_row_reg + ADDR_W'(dim_k));
                        b_addr_reg <= '0;
                    end
                    else
                    begin
                        state_reg <= S_DRAIN;
                    end
                end

                S_DRAIN:
                begin
                    // wait for the final sum to leave the pipeline
                    if (s2_valid_reg && s2_final_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // element stores and multiply-accumulate datapath
    always_ff @(posedge clk)
    begin
        if (accept && wr_a)
        begin
            a_mem[lc_eff[ADDR_W-1:0]] <= element;
        end
        if (accept && !wr_a)
        begin
            b_mem[lc_b[ADDR_W-1:0]] <= element;
        end
        a_q_reg  <= a_mem[a_addr_reg];
        b_q_reg  <= b_mem[b_addr_reg];
        prod_reg <= a_q_reg * b_q_reg;
        if (s2_valid_reg)
        begin
            acc_reg <= acc_next;
        end
        if (s2_valid_reg && s2_end_reg)
        begin
            product_reg <= acc_next;
        end
    end

    assign done    = done_reg;
    assign last    = last_reg;
    assign product = product_reg;

endmodule

`default_nettype wire

// ----- rtl/core/mm_checker.sv -----
// port-level checker for the matrix multiply block, bound to the top level
`default_nettype none

module mm_checker
    import mm_pkg::*;
(
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     start,
    input wire logic                     busy,
    input wire logic                     done,
    input wire logic                     last,
    input wire logic signed [ACC_W-1:0]  product
);

    // a result other than the final one only appears while computing
    assert property (@(posedge clk) disable iff (!rst_n)
        done && !last |-> busy)
        else $error("non-final result while not busy");

    // last is only raised on a result word
    assert property (@(posedge clk) disable iff (!rst_n)
        last |-> done)
        else $error("last without done");

    // a taken input word never produces a result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> !done)
        else $error("result right after an accepted word");

    // after the final result the block is idle
    assert property (@(posedge clk) disable iff (!rst_n)
        done && last |=> !busy)
        else $error("still busy after final result");

    // computation never starts with a result already showing
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> !done && !$isunknown(product) || !done)
        else $error("result at start of computation");

endmodule

bind matrix_multiply mm_checker u_mm_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .done    (done),
    .last    (last),
    .product (product)
);

`default_nettype wire

// ----- bench/tb_top.sv -----
// self-checking bench for the matrix multiply block: shaped loads, random data, product check
`timescale 1ns / 100ps

module tb_top;
    import mm_pkg::*;

    // index with no register behind it
    localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 2000;
    localparam int MAX_REPORTS = 20;

    typedef struct packed {
        logic signed [ACC_W-1:0] product;
        logic                    last;
    } product_word_t;

    // clock and reset
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // block inputs, known from time zero
    logic                     cfg_valid = 1'b0;
    logic [IDX_W-1:0]         cfg_index = '0;
    logic [CFG_W-1:0]         cfg_data = '0;
    logic                     start = 1'b0;
    logic signed [ELEM_W-1:0] element = '0;

    // block outputs
    logic                    cfg_ready;
    logic                    busy;
    logic                    done;
    logic signed [ACC_W-1:0] product;
    logic                    last;

    // predictor state: raw dimension registers, stores and load position
    logic [CFG_W-1:0]         dim_rows = 4'd1;
    logic [CFG_W-1:0]         dim_inner = 4'd1;
    logic [CFG_W-1:0]         dim_cols = 4'd1;
    logic signed [ELEM_W-1:0] a_words [STORE_DEPTH];
    logic signed [ELEM_W-1:0] b_words [STORE_DEPTH];
    int                       load_pos = 0;

    // product words still to come, oldest first
    product_word_t pending_products[$];

    // bookkeeping
    int err_cnt = 0;
    int words_sent = 0;
    int products_checked = 0;
    int cfg_writes = 0;
    int matrices_done = 0;
    int stall_cnt = 0;
    int idle_pct = 0;

    matrix_multiply dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .start     (start),
        .busy      (busy),
        .element   (element),
        .done      (done),
        .product   (product),
        .last      (last)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // a raw register value of zero acts as one, anything above MAX_DIM as MAX_DIM
    function automatic int clamp_dim(input logic [CFG_W-1:0] raw);
        int d;
        d = int'(raw);
        if (d < 1)
            d = 1;
        if (d > MAX_DIM)
            d = MAX_DIM;
        return d;
    endfunction

    // extremes and small values mixed in with full-range words
    function automatic logic signed [ELEM_W-1:0] random_element();
        logic signed [ELEM_W-1:0] v;
        case ($urandom_range(9))
            0: v = 16'sh8000;
            1: v = 16'sh7FFF;
            2: v = '0;
            3: v = ELEM_W'($urandom_range(0, 15)) - 16'sd8;
            default: v = ELEM_W'($urandom);
        endcase
        return v;
    endfunction

    // mostly small shapes, now and then zero or an oversized code
    function automatic logic [CFG_W-1:0] random_dim_code();
        logic [CFG_W-1:0] code;
        case ($urandom_range(19))
            0: code = '0;
            1: code = CFG_W'($urandom_range(9, 15));
            default: code = CFG_W'($urandom_range(1, 4));
        endcase
        return code;
    endfunction

    // register write as seen by the block
    task automatic apply_register(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        case (idx)
            REG_ROWS_A:
            begin
                dim_rows = data;
                load_pos = 0;
            end
            REG_INNER_DIM:
            begin
                dim_inner = data;
                load_pos = 0;
            end
            REG_COLS_B:
            begin
                dim_cols = data;
                load_pos = 0;
            end
            default: ;
        endcase
    endtask

    // full-precision product of the stored matrices, row-major
    task automatic compute_product_matrix(input int m, input int k, input int n);
        longint        acc;
        product_word_t word;
        for (int i = 0; i < m; i++)
        begin
            for (int j = 0; j < n; j++)
            begin
                acc = 0;
                for (int t = 0; t < k; t++)
                    acc += longint'(a_words[i * k + t]) * longint'(b_words[t * n + j]);
                word.product = acc[ACC_W-1:0];
                word.last = (i == m - 1) && (j == n - 1);
                pending_products.insert(pending_products.size(), word);
            end
        end
        matrices_done++;
    endtask

    // store one accepted word; the last word of B releases the whole product
    task automatic take_element(input logic signed [ELEM_W-1:0] v);
        int m;
        int k;
        int n;
        int size_a;
        int size_b;
        m = clamp_dim(dim_rows);
        k = clamp_dim(dim_inner);
        n = clamp_dim(dim_cols);
        size_a = m * k;
        size_b = k * n;
        if (load_pos >= size_a + size_b)
            load_pos = 0;
        if (load_pos < size_a)
            a_words[load_pos] = v;
        else
            b_words[load_pos - size_a] = v;
        load_pos++;
        if (load_pos == size_a + size_b)
        begin
            load_pos = 0;
            compute_product_matrix(m, k, n);
        end
    endtask

    // send one word, idling first at the current rate; start stays high on return
    task automatic send_element(input logic signed [ELEM_W-1:0] v);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            element <= ELEM_W'($urandom);
            @(posedge clk);
        end
        start <= 1'b1;
        element <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        take_element(v);
        words_sent++;
    endtask

    // stop sending and wait until every product word is in and the block is idle
    task automatic wait_products_drained();
        start <= 1'b0;
        while (pending_products.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // one register write on the configuration channel
    task automatic write_register(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        start <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_register(idx, data);
        cfg_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_shape(input logic [CFG_W-1:0] m, input logic [CFG_W-1:0] k,
                             input logic [CFG_W-1:0] n);
        wait_products_drained();
        write_register(REG_ROWS_A, m);
        write_register(REG_INNER_DIM, k);
        write_register(REG_COLS_B, n);
    endtask

    task automatic send_random_words(input int count);
        for (int i = 0; i < count; i++)
            send_element(random_element());
    endtask

    // 1x1x1 after reset: full-scale words, most negative squared
    task automatic test_reset_shape_extremes();
        send_element(16'sh7FFF);
        send_element(16'sh8000);
        send_element(16'sh8000);
        send_element(16'sh8000);
    endtask

    // row times column with extreme words on both sides
    task automatic test_row_by_column();
        set_shape(4'd1, 4'd2, 4'd1);
        send_element(16'sh8000);
        send_element(16'sh7FFF);
        send_element(16'sh8000);
        send_element(16'shFFFF);
    endtask

    // zero codes behave as dimension one
    task automatic test_zero_dims();
        set_shape(4'd0, 4'd0, 4'd0);
        send_element(16'sh0100);
        send_element(16'shFF00);
    endtask

    // oversized row code clamps to MAX_DIM
    task automatic test_clamped_rows();
        set_shape(4'd15, 4'd1, 4'd1);
        for (int i = 0; i < MAX_DIM; i++)
            send_element(ELEM_W'(16'sh1000 * i) - 16'sh4000);
        send_element(16'sh8000);
    endtask

    // a write in the middle of loading A starts the load over
    task automatic test_restart_on_write();
        set_shape(4'd1, 4'd2, 4'd1);
        send_element(16'sh1234);
        wait_products_drained();
        write_register(REG_INNER_DIM, 4'd1);
        send_element(16'sh0200);
        send_element(16'shFD00);
    endtask

    // a write to an unused index changes nothing, not even the load position
    task automatic test_unused_index();
        send_element(16'sh7FFF);
        wait_products_drained();
        write_register(REG_UNUSED, 4'd15);
        send_element(16'sh7FFF);
    endtask

    // random shapes and data, some loads cut short, some pauses until drained
    task automatic test_random_phase(input int pct, input int quota);
        int first_word;
        int pairs;
        int total;
        first_word = words_sent;
        idle_pct = pct;
        while (words_sent - first_word < quota)
        begin
            set_shape(random_dim_code(), random_dim_code(), random_dim_code());
            if ($urandom_range(3) == 0)
                write_register(REG_UNUSED, CFG_W'($urandom));
            total = clamp_dim(dim_rows) * clamp_dim(dim_inner)
                  + clamp_dim(dim_inner) * clamp_dim(dim_cols);
            pairs = $urandom_range(1, 3);
            for (int p = 0; p < pairs; p++)
            begin
                if ($urandom_range(7) == 0)
                begin
                    // broken load, abandoned by the next register write
                    send_random_words($urandom_range(1, total - 1));
                    break;
                end
                send_random_words(total);
                if ($urandom_range(3) == 0)
                    wait_products_drained();
            end
        end
    endtask

    // largest shape, every dimension code oversized or at the top
    task automatic test_full_size();
        idle_pct = 0;
        set_shape(4'd8, 4'd10, 4'd15);
        send_random_words(2 * STORE_DEPTH);
        set_shape(4'd1, 4'd1, 4'd1);
        send_random_words(2);
    endtask

    // result checker: each strobed word against the oldest expectation
    product_word_t exp_word;
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_products.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= MAX_REPORTS)
                    $display("%0t: unexpected product word %0d last %0b", $time, product, last);
            end
            else
            begin
                exp_word = pending_products.pop_front();
                products_checked++;
                if (product !== exp_word.product)
                begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display("%0t: product expected %0d got %0d",
                                 $time, exp_word.product, product);
                end
                if (last !== exp_word.last)
                begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display("%0t: last expected %0b got %0b", $time, exp_word.last, last);
                end
            end
        end
    end

    // watchdog on cycles with no word moving anywhere
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                stall_cnt <= 0;
            else
                stall_cnt <= stall_cnt + 1;
            if (stall_cnt >= STALL_LIMIT)
            begin
                $display("%0t: no traffic for %0d cycles, %0d product words outstanding",
                         $time, STALL_LIMIT, pending_products.size());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // test sequence
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_pct = 17;
        test_reset_shape_extremes();
        test_row_by_column();
        test_zero_dims();
        test_clamped_rows();
        test_restart_on_write();
        test_unused_index();

        test_random_phase(17, 50);
        test_random_phase(65, 50);
        test_random_phase(0, 40);
        test_full_size();

        wait_products_drained();
        repeat (16) @(posedge clk);

        $display("sent %0d matrix words, checked %0d product words of %0d matrices",
                 words_sent, products_checked, matrices_done);
        $display("%0d register writes, shapes from 1x1x1 to 8x8x8, sender idle 17/65/0 pct",
                 cfg_writes);
        if (err_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
